### rtl/lrk_pkg.sv
// Shared types, constants and the step microprogram of the Lorenz RK4 step core.
package lrk_pkg;

  localparam int WORD_BITS     = 48;
  localparam int FRAC_BITS     = 24;
  localparam int GAIN_BITS     = 47;
  localparam int CNT_BITS      = 32;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 47;

  localparam int IN_DATA_BITS  = 3 * WORD_BITS;
  localparam int OUT_DATA_BITS = 4 * WORD_BITS;

  localparam int DIGIT_BITS    = WORD_BITS / 2;
  localparam int D6_SHIFT      = WORD_BITS + 8;
  localparam int MUL_PASSES    = (D6_SHIFT + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int MB_BITS       = MUL_PASSES * DIGIT_BITS;
  localparam int PROD_BITS     = WORD_BITS + 1 + MB_BITS;
  localparam int PASS_CNT_BITS = (MUL_PASSES > 1) ? $clog2(MUL_PASSES) : 1;

  localparam logic [MB_BITS-1:0] D6_MULT =
    ((MB_BITS'(1) << D6_SHIFT) + MB_BITS'(5)) / MB_BITS'(6);

  localparam logic signed [WORD_BITS-1:0] W_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] W_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  localparam logic [GAIN_BITS-1:0] SIGMA_RST = GAIN_BITS'(167772160);
  localparam logic [GAIN_BITS-1:0] BETA_RST  = GAIN_BITS'(44739243);
  localparam logic [GAIN_BITS-1:0] RHO_RST   = GAIN_BITS'(469762048);
  localparam logic [GAIN_BITS-1:0] DT_RST    = GAIN_BITS'(83886);
  localparam logic [CNT_BITS-1:0]  WARM_RST  = CNT_BITS'(5000);
  localparam logic [GAIN_BITS-1:0] THR_RST   = GAIN_BITS'(8388608);

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  localparam int PROG_LEN = 81;
  localparam int PC_BITS  = 7;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SIGMA, CFG_BETA, CFG_RHO, CFG_DT, CFG_WARM, CFG_THR
  } cfg_idx_t;

  typedef enum logic [2:0] {OP_ADD, OP_SUB, OP_ADDH, OP_MUL, OP_DIV6} op_t;

  typedef enum logic [4:0] {
    S_ZERO, S_PX, S_PY, S_PZ, S_EX, S_EY, S_EZ, S_KX, S_KY, S_KZ,
    S_SX, S_SY, S_SZ, S_T0, S_T1, S_SIG, S_BET, S_RHO, S_DT
  } src_t;

  typedef enum logic [3:0] {
    D_PX, D_PY, D_PZ, D_EX, D_EY, D_EZ, D_KX, D_KY, D_KZ,
    D_SX, D_SY, D_SZ, D_T0, D_T1, D_CS
  } dst_t;

  typedef struct packed {
    op_t  op;
    src_t a;
    src_t b;
    dst_t d;
  } uop_t;

  typedef enum logic [2:0] {ST_IDLE, ST_EXEC, ST_MWAIT, ST_FIN, ST_OUT} ctrl_state_t;

  typedef struct packed {
    logic load;
    logic fin;
    logic out_load;
    logic alu_wr;
    logic mul_start;
    logic mul_wr;
    uop_t uop;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
  } dp_sts_t;

  function automatic src_t src_ax(input src_t base, input logic [1:0] axis);
    return src_t'(5'(base) + 5'(axis));
  endfunction

  function automatic dst_t dst_ax(input dst_t base, input logic [1:0] axis);
    return dst_t'(4'(base) + 4'(axis));
  endfunction

  function automatic uop_t deriv_op(input logic [2:0] i);
    uop_t u;
    unique case (i)
      3'd0: u = '{OP_SUB, S_EY, S_EX, D_T0};
      3'd1: u = '{OP_MUL, S_SIG, S_T0, D_KX};
      3'd2: u = '{OP_SUB, S_RHO, S_EZ, D_T0};
      3'd3: u = '{OP_MUL, S_EX, S_T0, D_T0};
      3'd4: u = '{OP_SUB, S_T0, S_EY, D_KY};
      3'd5: u = '{OP_MUL, S_EX, S_EY, D_T0};
      3'd6: u = '{OP_MUL, S_BET, S_EZ, D_T1};
      default: u = '{OP_SUB, S_T0, S_T1, D_KZ};
    endcase
    return u;
  endfunction

  function automatic uop_t eval_op(input logic [2:0] i, input op_t aop);
    uop_t u;
    if (!i[0]) begin
      u = '{OP_MUL, src_ax(S_KX, i[2:1]), S_DT, D_T0};
    end else begin
      u = '{aop, src_ax(S_PX, i[2:1]), S_T0, dst_ax(D_EX, i[2:1])};
    end
    return u;
  endfunction

  function automatic uop_t acc_op(input logic [1:0] axis);
    return '{OP_ADD, src_ax(S_SX, axis), src_ax(S_KX, axis), dst_ax(D_SX, axis)};
  endfunction

  function automatic uop_t final_op(input logic [1:0] axis, input logic [1:0] k);
    uop_t u;
    unique case (k)
      2'd0:    u = '{OP_MUL, src_ax(S_SX, axis), S_DT, D_T0};
      2'd1:    u = '{OP_DIV6, S_T0, S_ZERO, D_T0};
      default: u = '{OP_ADD, src_ax(S_PX, axis), S_T0, dst_ax(D_PX, axis)};
    endcase
    return u;
  endfunction

  function automatic uop_t uop_rom(input logic [PC_BITS-1:0] pc);
    uop_t u;
    case (pc) inside
      [7'd0:7'd2]:   u = '{OP_ADD, src_ax(S_PX, 2'(pc)), S_ZERO, dst_ax(D_EX, 2'(pc))};
      [7'd3:7'd10]:  u = deriv_op(3'(pc - 7'd3));
      7'd11:         u = '{OP_ADD, S_KZ, S_ZERO, D_CS};
      [7'd12:7'd14]: u = '{OP_ADD, src_ax(S_KX, 2'(pc - 7'd12)), S_ZERO,
                           dst_ax(D_SX, 2'(pc - 7'd12))};
      [7'd15:7'd20]: u = eval_op(3'(pc - 7'd15), OP_ADDH);
      [7'd21:7'd28]: u = deriv_op(3'(pc - 7'd21));
      [7'd29:7'd34]: u = acc_op(2'((pc - 7'd29) >> 1));
      [7'd35:7'd40]: u = eval_op(3'(pc - 7'd35), OP_ADDH);
      [7'd41:7'd48]: u = deriv_op(3'(pc - 7'd41));
      [7'd49:7'd54]: u = acc_op(2'((pc - 7'd49) >> 1));
      [7'd55:7'd60]: u = eval_op(3'(pc - 7'd55), OP_ADD);
      [7'd61:7'd68]: u = deriv_op(3'(pc - 7'd61));
      [7'd69:7'd71]: u = acc_op(2'(pc - 7'd69));
      [7'd72:7'd74]: u = final_op(2'd0, 2'(pc - 7'd72));
      [7'd75:7'd77]: u = final_op(2'd1, 2'(pc - 7'd75));
      [7'd78:7'd80]: u = final_op(2'd2, 2'(pc - 7'd78));
      default:       u = '{OP_ADD, S_ZERO, S_ZERO, D_T1};
    endcase
    return u;
  endfunction

  function automatic logic signed [WORD_BITS-1:0] sat_word(
    input logic signed [WORD_BITS:0] v
  );
    logic signed [WORD_BITS-1:0] r;
    if (v[WORD_BITS] != v[WORD_BITS-1]) begin
      r = v[WORD_BITS] ? W_MIN : W_MAX;
    end else begin
      r = v[WORD_BITS-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/lrk_mul.sv
// Sequential unsigned multiplier, one digit of the second operand per clock.
module lrk_mul (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [lrk_pkg::WORD_BITS-1:0]  a_mag,
  input  logic [lrk_pkg::MB_BITS-1:0]    b_mag,
  input  logic [lrk_pkg::WORD_BITS-1:0]  bias,
  output logic [lrk_pkg::PROD_BITS-1:0]  prod,
  output logic                           done
);
  import lrk_pkg::*;

  logic [WORD_BITS-1:0]            a_r, a_nxt;
  logic [MB_BITS-1:0]              b_r, b_nxt;
  logic [WORD_BITS:0]              hi_r, hi_nxt;
  logic [MB_BITS-1:0]              lo_r, lo_nxt;
  logic [PASS_CNT_BITS-1:0]        cnt_r, cnt_nxt;
  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [WORD_BITS+DIGIT_BITS-1:0] pp;
  logic [WORD_BITS+DIGIT_BITS:0]   sum;

  assign pp  = a_r * b_r[DIGIT_BITS-1:0];
  assign sum = (WORD_BITS+DIGIT_BITS+1)'(hi_r) + (WORD_BITS+DIGIT_BITS+1)'(pp);

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = a_mag;
      b_nxt    = b_mag;
      hi_nxt   = {1'b0, bias};
      lo_nxt   = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      hi_nxt  = sum[WORD_BITS+DIGIT_BITS:DIGIT_BITS];
      lo_nxt  = {sum[DIGIT_BITS-1:0], lo_r[MB_BITS-1:DIGIT_BITS]};
      b_nxt   = b_r >> DIGIT_BITS;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == PASS_CNT_BITS'(MUL_PASSES - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r  <= a_nxt;
    b_r  <= b_nxt;
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
  end

  assign prod = {hi_r, lo_r};
  assign done = done_r;

endmodule

### rtl/lrk_datapath.sv
// Datapath: state, working registers, saturating adder, multiplier and result register.
module lrk_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic signed [lrk_pkg::WORD_BITS-1:0] in_x,
  input  logic signed [lrk_pkg::WORD_BITS-1:0] in_y,
  input  logic signed [lrk_pkg::WORD_BITS-1:0] in_z,
  input  logic                              cfg_wr,
  input  logic [lrk_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [lrk_pkg::CFG_DATA_BITS-1:0] cfg_val,
  input  lrk_pkg::dp_cmd_t                  cmd,
  output lrk_pkg::dp_sts_t                  sts,
  output logic signed [lrk_pkg::WORD_BITS-1:0] out_x,
  output logic signed [lrk_pkg::WORD_BITS-1:0] out_y,
  output logic signed [lrk_pkg::WORD_BITS-1:0] out_z,
  output logic signed [lrk_pkg::WORD_BITS-1:0] out_slope,
  output logic                              out_flag
);
  import lrk_pkg::*;

  typedef logic signed [WORD_BITS-1:0] word_t;

  word_t px_r, py_r, pz_r, ex_r, ey_r, ez_r, kx_r, ky_r, kz_r;
  word_t sx_r, sy_r, sz_r, t0_r, t1_r, cs_r;
  word_t px_nxt, py_nxt, pz_nxt, ex_nxt, ey_nxt, ez_nxt, kx_nxt, ky_nxt, kz_nxt;
  word_t sx_nxt, sy_nxt, sz_nxt, t0_nxt, t1_nxt, cs_nxt;
  logic [GAIN_BITS-1:0] sig_r, bet_r, rho_r, dt_r, thr_r;
  logic [CNT_BITS-1:0]  warm_r, cnt_r, cnt_nxt;
  logic                 flag_r, flag_nxt, neg_r, neg_nxt;
  word_t ox_r, oy_r, oz_r, os_r;
  logic                 of_r;

  word_t a_val, b_val, b_opnd, alu_res, mul_res, wdata, cs_mag;
  logic signed [WORD_BITS:0] alu_sum;
  logic                      wen;
  logic [WORD_BITS-1:0]      m_a, m_bias;
  logic [MB_BITS-1:0]        m_b;
  logic [PROD_BITS-1:0]      prod;
  logic                      m_done;
  logic [PROD_BITS-FRAC_BITS-1:0] q_fx;
  logic [PROD_BITS-D6_SHIFT-1:0]  q_d6;
  logic                           fx_ovf;

  function automatic word_t rd(input src_t s);
    word_t v;
    unique case (s)
      S_ZERO:  v = '0;
      S_PX:    v = px_r;
      S_PY:    v = py_r;
      S_PZ:    v = pz_r;
      S_EX:    v = ex_r;
      S_EY:    v = ey_r;
      S_EZ:    v = ez_r;
      S_KX:    v = kx_r;
      S_KY:    v = ky_r;
      S_KZ:    v = kz_r;
      S_SX:    v = sx_r;
      S_SY:    v = sy_r;
      S_SZ:    v = sz_r;
      S_T0:    v = t0_r;
      S_T1:    v = t1_r;
      S_SIG:   v = WORD_BITS'(sig_r);
      S_BET:   v = WORD_BITS'(bet_r);
      S_RHO:   v = WORD_BITS'(rho_r);
      S_DT:    v = WORD_BITS'(dt_r);
      default: v = '0;
    endcase
    return v;
  endfunction

  assign a_val  = rd(cmd.uop.a);
  assign b_val  = rd(cmd.uop.b);
  assign b_opnd = (cmd.uop.op == OP_ADDH) ? (b_val >>> 1) : b_val;

  always_comb begin
    if (cmd.uop.op == OP_SUB) begin
      alu_sum = {a_val[WORD_BITS-1], a_val} - {b_opnd[WORD_BITS-1], b_opnd};
    end else begin
      alu_sum = {a_val[WORD_BITS-1], a_val} + {b_opnd[WORD_BITS-1], b_opnd};
    end
    alu_res = sat_word(alu_sum);
  end

  always_comb begin
    if (cmd.uop.op == OP_DIV6) begin
      neg_nxt = a_val[WORD_BITS-1];
      m_a     = neg_nxt ? (WORD_BITS'(-a_val) + WORD_BITS'(5)) : WORD_BITS'(a_val);
      m_b     = D6_MULT;
      m_bias  = '0;
    end else begin
      neg_nxt = a_val[WORD_BITS-1] ^ b_val[WORD_BITS-1];
      m_a     = a_val[WORD_BITS-1] ? WORD_BITS'(-a_val) : WORD_BITS'(a_val);
      m_b     = MB_BITS'($unsigned(b_val[WORD_BITS-1] ? -b_val : b_val));
      m_bias  = neg_nxt ? WORD_BITS'((WORD_BITS+1)'(1) << FRAC_BITS) - 1'b1 : '0;
    end
  end

  lrk_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a_mag (m_a),
    .b_mag (m_b),
    .bias  (m_bias),
    .prod  (prod),
    .done  (m_done)
  );

  assign sts.mul_done = m_done;

  always_comb begin
    q_fx   = prod[PROD_BITS-1:FRAC_BITS];
    q_d6   = prod[PROD_BITS-1:D6_SHIFT];
    fx_ovf = |q_fx[PROD_BITS-FRAC_BITS-1:WORD_BITS-1];
    if (cmd.uop.op == OP_DIV6) begin
      mul_res = neg_r ? -word_t'(q_d6[WORD_BITS-1:0]) : word_t'(q_d6[WORD_BITS-1:0]);
    end else if (fx_ovf) begin
      mul_res = neg_r ? W_MIN : W_MAX;
    end else begin
      mul_res = neg_r ? -word_t'(q_fx[WORD_BITS-1:0]) : word_t'(q_fx[WORD_BITS-1:0]);
    end
  end

  assign wen    = cmd.alu_wr | cmd.mul_wr;
  assign wdata  = cmd.mul_wr ? mul_res : alu_res;
  assign cs_mag = cs_r[WORD_BITS-1] ? -cs_r : cs_r;

  always_comb begin
    px_nxt = px_r; py_nxt = py_r; pz_nxt = pz_r;
    ex_nxt = ex_r; ey_nxt = ey_r; ez_nxt = ez_r;
    kx_nxt = kx_r; ky_nxt = ky_r; kz_nxt = kz_r;
    sx_nxt = sx_r; sy_nxt = sy_r; sz_nxt = sz_r;
    t0_nxt = t0_r; t1_nxt = t1_r; cs_nxt = cs_r;
    cnt_nxt  = cnt_r;
    flag_nxt = flag_r;
    if (cmd.load) begin
      px_nxt   = in_x;
      py_nxt   = in_y;
      pz_nxt   = in_z;
      cs_nxt   = '0;
      cnt_nxt  = '0;
      flag_nxt = 1'b0;
    end else if (cmd.fin) begin
      flag_nxt = (cnt_r >= warm_r) && (WORD_BITS'(cs_mag) < WORD_BITS'(thr_r));
      if (cnt_r != '1) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end else if (wen) begin
      unique case (cmd.uop.d)
        D_PX:    px_nxt = wdata;
        D_PY:    py_nxt = wdata;
        D_PZ:    pz_nxt = wdata;
        D_EX:    ex_nxt = wdata;
        D_EY:    ey_nxt = wdata;
        D_EZ:    ez_nxt = wdata;
        D_KX:    kx_nxt = wdata;
        D_KY:    ky_nxt = wdata;
        D_KZ:    kz_nxt = wdata;
        D_SX:    sx_nxt = wdata;
        D_SY:    sy_nxt = wdata;
        D_SZ:    sz_nxt = wdata;
        D_T0:    t0_nxt = wdata;
        D_T1:    t1_nxt = wdata;
        D_CS:    cs_nxt = wdata;
        default: t1_nxt = t1_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r   <= '0;
      py_r   <= '0;
      pz_r   <= '0;
      cnt_r  <= '0;
      sig_r  <= SIGMA_RST;
      bet_r  <= BETA_RST;
      rho_r  <= RHO_RST;
      dt_r   <= DT_RST;
      warm_r <= WARM_RST;
      thr_r  <= THR_RST;
    end else begin
      px_r  <= px_nxt;
      py_r  <= py_nxt;
      pz_r  <= pz_nxt;
      cnt_r <= cnt_nxt;
      if (cfg_wr) begin
        unique case (cfg_idx)
          CFG_SIGMA: sig_r  <= cfg_val[GAIN_BITS-1:0];
          CFG_BETA:  bet_r  <= cfg_val[GAIN_BITS-1:0];
          CFG_RHO:   rho_r  <= cfg_val[GAIN_BITS-1:0];
          CFG_DT:    dt_r   <= cfg_val[GAIN_BITS-1:0];
          CFG_WARM:  warm_r <= cfg_val[CNT_BITS-1:0];
          CFG_THR:   thr_r  <= cfg_val[GAIN_BITS-1:0];
          default:   thr_r  <= thr_r;
        endcase
      end
    end
    ex_r <= ex_nxt; ey_r <= ey_nxt; ez_r <= ez_nxt;
    kx_r <= kx_nxt; ky_r <= ky_nxt; kz_r <= kz_nxt;
    sx_r <= sx_nxt; sy_r <= sy_nxt; sz_r <= sz_nxt;
    t0_r <= t0_nxt; t1_r <= t1_nxt; cs_r <= cs_nxt;
    flag_r <= flag_nxt;
    if (cmd.mul_start) begin
      neg_r <= neg_nxt;
    end
    if (cmd.out_load) begin
      ox_r <= px_r;
      oy_r <= py_r;
      oz_r <= pz_r;
      os_r <= cs_r;
      of_r <= flag_r;
    end
  end

  assign out_x     = ox_r;
  assign out_y     = oy_r;
  assign out_z     = oz_r;
  assign out_slope = os_r;
  assign out_flag  = of_r;

endmodule

### rtl/lrk_ctrl.sv
// Controller: request handshakes and the microprogram sequencer for one RK4 step.
module lrk_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_func,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  output lrk_pkg::dp_cmd_t  cmd,
  input  lrk_pkg::dp_sts_t  sts
);
  import lrk_pkg::*;

  ctrl_state_t          state_r, state_nxt;
  logic [PC_BITS-1:0]   pc_r, pc_nxt;
  logic                 ov_r, ov_nxt;
  uop_t                 uop;
  logic                 is_mul, last, out_free;

  assign uop      = uop_rom(pc_r);
  assign is_mul   = (uop.op == OP_MUL) || (uop.op == OP_DIV6);
  assign last     = (pc_r == PC_BITS'(PROG_LEN - 1));
  assign out_free = !ov_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          pc_nxt    = '0;
          state_nxt = (in_func == FUNC_STEP) ? ST_EXEC : ST_OUT;
        end
      end
      ST_EXEC: begin
        if (is_mul) begin
          state_nxt = ST_MWAIT;
        end else if (last) begin
          state_nxt = ST_FIN;
        end else begin
          pc_nxt = pc_r + 1'b1;
        end
      end
      ST_MWAIT: begin
        if (sts.mul_done) begin
          if (last) begin
            state_nxt = ST_FIN;
          end else begin
            pc_nxt    = pc_r + 1'b1;
            state_nxt = ST_EXEC;
          end
        end
      end
      ST_FIN: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state_r == ST_IDLE);
    cmd.uop       = uop;
    cmd.load      = (state_r == ST_IDLE) && in_valid && (in_func == FUNC_LOAD);
    cmd.alu_wr    = (state_r == ST_EXEC) && !is_mul;
    cmd.mul_start = (state_r == ST_EXEC) && is_mul;
    cmd.mul_wr    = (state_r == ST_MWAIT) && sts.mul_done;
    cmd.fin       = (state_r == ST_FIN);
    cmd.out_load  = (state_r == ST_OUT) && out_free;
    if (cmd.out_load) begin
      ov_nxt = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pc_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign out_valid = ov_r;

endmodule

### rtl/lorenz_rk4_step_core.sv
// Top level of the fixed-point Lorenz system RK4 step core.
//
//  Channel  Direction  Handshake          Contents
//  in_      slave      tvalid / tready    tdata: x_init, y_init, z_init; tuser: func
//  out_     master     tvalid / tready    tdata: x_now, y_now, z_now, z_slope;
//                                         tuser: sample_flag
//  cfg_     slave      valid / ready      index, data of one configuration register
//
// A load result passes from the output state into the output register once that is free.
// A step request runs 81 microinstructions: 50 adds and 31 products on the one
// 48 x 24 bit multiplier, whose result the sequencer waits for; after the last
// microinstruction come the finish and output states.
// The next request is taken once the result has moved into the output register.
// Reset is synchronous and active low; it restores the register defaults at once.
// A stalled output holds its request; configuration writes are always taken.
module lorenz_rk4_step_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [lrk_pkg::IN_DATA_BITS-1:0]    in_tdata,   // x_init, y_init, z_init
  input  logic                                in_tuser,   // func
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [lrk_pkg::OUT_DATA_BITS-1:0]   out_tdata,  // x_now, y_now, z_now, z_slope
  output logic                                out_tuser,  // sample_flag
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lrk_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [lrk_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import lrk_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic signed [WORD_BITS-1:0] ox, oy, oz, os;

  assign cfg_ready = 1'b1;

  lrk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_func   (in_tuser),
    .in_ready  (in_tready),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .cmd       (cmd),
    .sts       (sts)
  );

  lrk_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_x      (in_tdata[WORD_BITS-1:0]),
    .in_y      (in_tdata[2*WORD_BITS-1:WORD_BITS]),
    .in_z      (in_tdata[3*WORD_BITS-1:2*WORD_BITS]),
    .cfg_wr    (cfg_valid),
    .cfg_idx   (cfg_index),
    .cfg_val   (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_x     (ox),
    .out_y     (oy),
    .out_z     (oz),
    .out_slope (os),
    .out_flag  (out_tuser)
  );

  assign out_tdata = {os, oz, oy, ox};

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while the previous one was still in progress");

  a_done_written: assert property (@(posedge clk) disable iff (!rst_n)
    sts.mul_done |-> cmd.mul_wr)
    else $error("product finished with no sequencer waiting for it");

  a_mul_latency: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_start |=> !sts.mul_done)
    else $error("product reported finished one clock after start");
`endif

endmodule

### sim/lorenz_rk4_step_core_tb.sv
// Self-checking testbench for the Lorenz RK4 step core: predicts every result and compares it.
`timescale 1ns / 100ps

module lorenz_rk4_step_core_tb;
  import lrk_pkg::*;

  localparam int W = WORD_BITS;
  localparam int DRAIN_CYCLES = 400;

  typedef logic signed [W-1:0] word_t;

  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
    word_t slope;
    logic  flag;
  } lorenz_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_BITS-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  lorenz_rk4_step_core i_dut (.*);

  // Model state and configuration.
  logic [GAIN_BITS-1:0] m_sigma, m_beta, m_rho, m_dt, m_thr;
  logic [CNT_BITS-1:0] m_warm, m_steps;
  word_t m_x, m_y, m_z;

  lorenz_out_t expected_q[$];
  int mismatches = 0;
  int results_seen = 0;
  int samples_seen = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;

  initial forever #5 clk = ~clk;

  initial begin
    #200ms;
    $display("lorenz_rk4_step_core_tb NOT OK");
    $finish;
  end

  function automatic word_t sat_wide(input logic signed [127:0] v);
    if (v > 128'sh7FFF_FFFF_FFFF) return W_MAX;
    if (v < -128'sh8000_0000_0000) return W_MIN;
    return word_t'(v);
  endfunction

  function automatic word_t s_add(input word_t a, input word_t b);
    return sat_wide(128'(a) + 128'(b));
  endfunction

  function automatic word_t s_sub(input word_t a, input word_t b);
    return sat_wide(128'(a) - 128'(b));
  endfunction

  function automatic word_t fx_mul(input word_t a, input word_t b);
    logic signed [127:0] p;
    p = 128'(a) * 128'(b);
    return sat_wide(p >>> FRAC_BITS);
  endfunction

  function automatic word_t gain_w(input logic [GAIN_BITS-1:0] g);
    return word_t'({1'b0, g});
  endfunction

  function automatic word_t div6(input word_t v);
    logic signed [63:0] q, r;
    q = 64'(v) / 6;
    r = 64'(v) % 6;
    if (r != 0 && v < 0) q = q - 1;
    return word_t'(q);
  endfunction

  task automatic lorenz_deriv(input word_t x, input word_t y, input word_t z,
                              output word_t dx, output word_t dy, output word_t dz);
    dx = fx_mul(gain_w(m_sigma), s_sub(y, x));
    dy = s_sub(fx_mul(x, s_sub(gain_w(m_rho), z)), y);
    dz = s_sub(fx_mul(x, y), fx_mul(gain_w(m_beta), z));
  endtask

  function automatic word_t rk_final(input word_t p, input word_t k1, input word_t k2,
                                     input word_t k3, input word_t k4, input word_t dt);
    word_t s;
    s = s_add(k1, k2);
    s = s_add(s, k2);
    s = s_add(s, k3);
    s = s_add(s, k3);
    s = s_add(s, k4);
    return s_add(p, div6(fx_mul(s, dt)));
  endfunction

  task automatic predict_lorenz(input logic func, input word_t xi, input word_t yi,
                                input word_t zi);
    lorenz_out_t r;
    word_t dt, a1, b1, c1, a2, b2, c2, a3, b3, c3, a4, b4, c4;
    r.slope = '0;
    r.flag = 1'b0;
    if (func == FUNC_LOAD) begin
      m_x = xi;
      m_y = yi;
      m_z = zi;
      m_steps = '0;
    end else begin
      dt = gain_w(m_dt);
      lorenz_deriv(m_x, m_y, m_z, a1, b1, c1);
      lorenz_deriv(s_add(m_x, fx_mul(a1, dt) >>> 1), s_add(m_y, fx_mul(b1, dt) >>> 1),
                   s_add(m_z, fx_mul(c1, dt) >>> 1), a2, b2, c2);
      lorenz_deriv(s_add(m_x, fx_mul(a2, dt) >>> 1), s_add(m_y, fx_mul(b2, dt) >>> 1),
                   s_add(m_z, fx_mul(c2, dt) >>> 1), a3, b3, c3);
      lorenz_deriv(s_add(m_x, fx_mul(a3, dt)), s_add(m_y, fx_mul(b3, dt)),
                   s_add(m_z, fx_mul(c3, dt)), a4, b4, c4);
      m_x = rk_final(m_x, a1, a2, a3, a4, dt);
      m_y = rk_final(m_y, b1, b2, b3, b4, dt);
      m_z = rk_final(m_z, c1, c2, c3, c4, dt);
      r.slope = c1;
      if (m_steps >= m_warm && (c1 < 0 ? -64'(c1) : 64'(c1)) < 64'(m_thr)) r.flag = 1'b1;
      if (m_steps != '1) m_steps = m_steps + 1;
    end
    r.x = m_x;
    r.y = m_y;
    r.z = m_z;
    expected_q = {expected_q, r};
  endtask

  task automatic send_request(input logic func, input word_t xi, input word_t yi,
                              input word_t zi);
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= func;
    in_tdata <= {zi, yi, xi};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_lorenz(func, xi, yi, zi);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_SIGMA: m_sigma = val;
      CFG_BETA:  m_beta = val;
      CFG_RHO:   m_rho = val;
      CFG_DT:    m_dt = val;
      CFG_WARM:  m_warm = val[CNT_BITS-1:0];
      CFG_THR:   m_thr = val;
      default: ;
    endcase
  endtask

  task automatic set_params(input logic [46:0] sg, input logic [46:0] bt,
                            input logic [46:0] rh, input logic [46:0] dt,
                            input logic [46:0] wm, input logic [46:0] th);
    write_reg(CFG_SIGMA, sg);
    write_reg(CFG_BETA, bt);
    write_reg(CFG_RHO, rh);
    write_reg(CFG_DT, dt);
    write_reg(CFG_WARM, wm);
    write_reg(CFG_THR, th);
    cfg_valid <= 1'b0;
  endtask

  function automatic word_t rand_word();
    word_t v;
    v = word_t'({$urandom, $urandom});
    case ($urandom_range(3, 0))
      0: v = W_MAX;
      1: v = W_MIN;
      2: v = v >>> $urandom_range(40, 20);
      default: ;
    endcase
    return v;
  endfunction

  function automatic word_t near_word(input int mag_int);
    return word_t'(($signed($urandom_range(2 * mag_int, 0)) - mag_int) * 64'sh100_0000)
           + word_t'($urandom_range(24'hFF_FFFF, 0));
  endfunction

  task automatic test_directed();
    send_request(FUNC_STEP, '0, '0, '0);
    send_request(FUNC_LOAD, W_MAX, W_MIN, W_MAX);
    send_request(FUNC_STEP, W_MIN, W_MIN, W_MIN);
    send_request(FUNC_LOAD, W_MIN, W_MAX, W_MIN);
    send_request(FUNC_STEP, '0, '0, '0);
    send_request(FUNC_LOAD, 48'sh100_0000, 48'sh100_0000, 48'sh100_0000);
    repeat (5) send_request(FUNC_STEP, W_MAX, W_MAX, W_MAX);
    send_request(FUNC_LOAD, -48'sd1, -48'sd1, -48'sd1);
    send_request(FUNC_STEP, '0, '0, '0);
    wait_drained();
    set_params('1, '1, '1, '1, '1, '1);
    send_request(FUNC_LOAD, 48'sh300_0000, -48'sh200_0000, 48'sh500_0000);
    repeat (3) send_request(FUNC_STEP, '0, '0, '0);
    wait_drained();
    set_params('0, '0, '0, '0, '0, '0);
    send_request(FUNC_LOAD, 48'sh300_0000, -48'sh200_0000, 48'sh500_0000);
    repeat (3) send_request(FUNC_STEP, '0, '0, '0);
    wait_drained();
    // Warm-up at its limit: a warm-up of all ones lets no flag through in these steps.
    set_params(47'd167772160, 47'd44739243, 47'd469762048, 47'd83886, 47'hFFFF_FFFF,
               '1);
    send_request(FUNC_LOAD, 48'sh100_0000, 48'sh100_0000, 48'sh100_0000);
    repeat (3) send_request(FUNC_STEP, '0, '0, '0);
    wait_drained();
  endtask

  task automatic test_random_orbits(input int n_items, input int idle_s, input int idle_r);
    send_idle_pct = idle_s;
    recv_stall_pct = idle_r;
    set_params(47'($urandom_range(30, 1)) << 24, 47'($urandom_range(8 << 24, 0)),
               47'($urandom_range(60, 0)) << 24, 47'($urandom_range(400000, 1)),
               47'($urandom_range(20, 0)), 47'($urandom_range(1 << 28, 1 << 22)));
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(19, 0) == 0)
        send_request(FUNC_LOAD, rand_word(), rand_word(), rand_word());
      else if ($urandom_range(9, 0) == 0)
        send_request(FUNC_LOAD, near_word(30), near_word(30), near_word(50));
      else
        send_request(FUNC_STEP, rand_word(), rand_word(), rand_word());
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 2000;
    for (int i = 0; i < 20; i++)
      send_request(i == 0 ? FUNC_LOAD : FUNC_STEP, near_word(10), near_word(10),
                   near_word(30));
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    lorenz_out_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[W-1:0], out_tdata[2*W-1:W], out_tdata[3*W-1:2*W],
             out_tdata[4*W-1:3*W], out_tuser};
      results_seen++;
      if (out_tuser) samples_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_q.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp x %h y %h z %h dz %h f %b, got x %h y %h z %h dz %h f %b",
                     want.x, want.y, want.z, want.slope, want.flag,
                     got.x, got.y, got.z, got.slope, got.flag);
        end
      end
    end
  end

  initial begin
    m_sigma = SIGMA_RST;
    m_beta = BETA_RST;
    m_rho = RHO_RST;
    m_dt = DT_RST;
    m_warm = WARM_RST;
    m_thr = THR_RST;
    m_x = '0;
    m_y = '0;
    m_z = '0;
    m_steps = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random_orbits(400, 0, 0);
    test_random_orbits(150, 88, 0);
    test_random_orbits(150, 0, 88);
    test_random_orbits(400, 18, 18);
    test_random_orbits(400, 0, 0);
    $display("Covered loads, RK4 steps at extreme and random settings, %0d results, %0d flagged.",
             results_seen, samples_seen);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("lorenz_rk4_step_core_tb OK");
    end else begin
      $display("lorenz_rk4_step_core_tb NOT OK");
    end
    $finish;
  end

endmodule
